// ----- rtl/sdbr_pkg.sv -----
// sdbr_pkg: shared types, constants and the crc helper for the sd data block receiver
// no dependencies; imported by sdbr_regs and sd_data_block_receiver
package sdbr_pkg;

  // register file geometry
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int BLOCK_LENGTH_W = 13;
  localparam int HUNT_LIMIT_W = 20;

  // register indexes
  localparam logic REG_BLOCK_LENGTH = 1'b0;
  localparam logic REG_HUNT_LIMIT = 1'b1;

  // reset values of the registers
  localparam logic [BLOCK_LENGTH_W-1:0] BLOCK_LENGTH_RESET = 13'd512;
  localparam logic [HUNT_LIMIT_W-1:0] HUNT_LIMIT_RESET = 20'd20000;

  // protocol constants
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // read sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HUNT = 3'd1,
    PH_DATA = 3'd2,
    PH_CRC_HI = 3'd3,
    PH_CRC_LO = 3'd4
  } phase_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [BLOCK_LENGTH_W-1:0] block_length;
    logic [HUNT_LIMIT_W-1:0] hunt_limit;
  } cfg_t;

  // crc-16/xmodem update by one byte, msb first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sdbr_regs.sv -----
// sdbr_regs: apb-style register file holding block_length and hunt_limit
// depends on sdbr_pkg
module sdbr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdbr_pkg::ADDR_W-1:0] paddr,
  input  logic [sdbr_pkg::DATA_W-1:0] pwdata,
  output logic [sdbr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sdbr_pkg::cfg_t              cfg
);
  import sdbr_pkg::*;

  logic reg_index;
  logic wr_en;

  // word address selects the register, byte offset bits are ignored
  assign reg_index = 1'(paddr >> 2);
  assign wr_en = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length <= BLOCK_LENGTH_RESET;
      cfg.hunt_limit <= HUNT_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_BLOCK_LENGTH: cfg.block_length <= pwdata[BLOCK_LENGTH_W-1:0];
        REG_HUNT_LIMIT:   cfg.hunt_limit <= pwdata[HUNT_LIMIT_W-1:0];
        default:          ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_index)
      REG_BLOCK_LENGTH: prdata = DATA_W'(cfg.block_length);
      REG_HUNT_LIMIT:   prdata = DATA_W'(cfg.hunt_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sd_data_block_receiver.sv -----
// sd_data_block_receiver: top level, sd spi-mode data block read with crc-16 check
// depends on sdbr_pkg and sdbr_regs
//
// Takes one byte or begin command per transfer on the item channel and gives at
// most one result per transfer: each payload byte, then a final status (ok, crc
// mismatch, or start token timeout) marked with last. A new item can be taken
// every clock cycle unless the result channel stalls; an item's result passes
// through the input register, then the result register. The rate is
// set by the single-pass byte-wide crc update and phase logic that sits between
// those two registers. A stall on the result channel holds the input register,
// which then stalls the item channel.
module sd_data_block_receiver (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdbr_pkg::ADDR_W-1:0] paddr,
  input  logic [sdbr_pkg::DATA_W-1:0] pwdata,
  output logic [sdbr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        cmd,
  input  logic [7:0]                  rx_byte,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        result_kind,
  output logic [7:0]                  data_byte,
  output logic [1:0]                  status,
  output logic                        last
);
  import sdbr_pkg::*;

  cfg_t cfg;

  // input register
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_byte;

  // sequencer state
  phase_t                    phase, phase_next;
  logic [HUNT_LIMIT_W-1:0]   hunt_count, hunt_count_next;
  logic [BLOCK_LENGTH_W-1:0] byte_count, byte_count_next;
  logic [15:0]               running_crc, running_crc_next;
  logic [7:0]                crc_high_byte, crc_high_byte_next;

  // result produced by the current item
  logic       emit;
  logic       emit_kind;
  logic [7:0] emit_data;
  logic [1:0] emit_status;

  logic out_free;
  logic advance;
  logic item_take;
  logic [HUNT_LIMIT_W-1:0]   hunt_inc;
  logic [BLOCK_LENGTH_W-1:0] byte_inc;
  logic [15:0]               crc_upd;

  sdbr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake between the two register stages
  assign out_free = !result_valid || !result_stall;
  assign advance = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign item_take = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_cmd <= cmd;
      s1_byte <= rx_byte;
    end
  end

  assign hunt_inc = hunt_count + 1'b1;
  assign byte_inc = byte_count + 1'b1;
  assign crc_upd = crc_add_byte(running_crc, s1_byte);

  // phase logic and result selection
  always_comb begin
    phase_next = phase;
    hunt_count_next = hunt_count;
    byte_count_next = byte_count;
    running_crc_next = running_crc;
    crc_high_byte_next = crc_high_byte;
    emit = 1'b0;
    emit_kind = KIND_DATA;
    emit_data = 8'h00;
    emit_status = STATUS_OK;
    if (s1_cmd) begin
      // begin command aborts any read and rearms the hunt
      phase_next = PH_HUNT;
      hunt_count_next = '0;
      byte_count_next = '0;
      running_crc_next = '0;
      crc_high_byte_next = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (s1_byte == START_TOKEN) begin
            byte_count_next = '0;
            running_crc_next = '0;
            phase_next = (cfg.block_length == '0) ? PH_CRC_HI : PH_DATA;
          end else begin
            hunt_count_next = hunt_inc;
            if (hunt_inc >= cfg.hunt_limit) begin
              phase_next = PH_IDLE;
              emit = 1'b1;
              emit_kind = KIND_STATUS;
              emit_status = STATUS_TIMEOUT;
            end
          end
        end
        PH_DATA: begin
          running_crc_next = crc_upd;
          byte_count_next = byte_inc;
          if (byte_inc >= cfg.block_length) begin
            phase_next = PH_CRC_HI;
          end
          emit = 1'b1;
          emit_data = s1_byte;
        end
        PH_CRC_HI: begin
          crc_high_byte_next = s1_byte;
          phase_next = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          phase_next = PH_IDLE;
          emit = 1'b1;
          emit_kind = KIND_STATUS;
          emit_status = ({crc_high_byte, s1_byte} == running_crc) ? STATUS_OK
                                                                   : STATUS_CRC_ERR;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      hunt_count <= '0;
      byte_count <= '0;
      running_crc <= '0;
      crc_high_byte <= '0;
    end else if (advance) begin
      phase <= phase_next;
      hunt_count <= hunt_count_next;
      byte_count <= byte_count_next;
      running_crc <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_kind <= emit_kind;
      data_byte <= emit_data;
      status <= emit_status;
      last <= emit_kind;
    end
  end

  // a byte while idle never produces a result
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_cmd && (phase == PH_IDLE) |=> !result_valid)
    else $error("result produced for a byte while idle");

  // a begin command rearms the hunt with cleared counters
  a_begin_rearms: assert property (@(posedge clk) disable iff (rst)
    advance && s1_cmd |=> (phase == PH_HUNT) && (hunt_count == '0)
                          && (byte_count == '0) && (running_crc == '0))
    else $error("begin command did not rearm the hunt");

  // the item channel stalls only while the input register holds an item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("item channel stalled with room in the pipeline");

endmodule
